// File: design/kbc_pkg.sv
`timescale 1ns / 1ps

package kbc_pkg;

    localparam int CmdWidth  = 3;
    localparam int ByteWidth = 8;
    localparam int KindWidth = 3;

    typedef enum logic [CmdWidth-1:0] {
        ACC_DATA_READ   = 3'd0,
        ACC_DATA_WRITE  = 3'd1,
        ACC_STATUS_READ = 3'd2,
        ACC_CMD_WRITE   = 3'd3,
        ACC_KBD_LEVEL   = 3'd4,
        ACC_AUX_LEVEL   = 3'd5
    } access_t;

    typedef enum logic [KindWidth-1:0] {
        FW_NONE       = 3'd0,
        FW_QUEUE_KBD  = 3'd1,
        FW_QUEUE_AUX  = 3'd2,
        FW_SEND_KBD   = 3'd3,
        FW_SEND_MOUSE = 3'd4,
        FW_READ_KBD   = 3'd5,
        FW_READ_AUX   = 3'd6
    } fwd_kind_t;

    // controller command bytes
    localparam logic [7:0] CMD_NONE         = 8'h00;
    localparam logic [7:0] CMD_READ_MODE    = 8'h20;
    localparam logic [7:0] CMD_WRITE_MODE   = 8'h60;
    localparam logic [7:0] CMD_AUX_DISABLE  = 8'hA7;
    localparam logic [7:0] CMD_AUX_ENABLE   = 8'hA8;
    localparam logic [7:0] CMD_AUX_TEST     = 8'hA9;
    localparam logic [7:0] CMD_SELF_TEST    = 8'hAA;
    localparam logic [7:0] CMD_KBD_TEST     = 8'hAB;
    localparam logic [7:0] CMD_KBD_DISABLE  = 8'hAD;
    localparam logic [7:0] CMD_KBD_ENABLE   = 8'hAE;
    localparam logic [7:0] CMD_READ_INPUT   = 8'hC0;
    localparam logic [7:0] CMD_READ_OUTPUT  = 8'hD0;
    localparam logic [7:0] CMD_WRITE_OUTPUT = 8'hD1;
    localparam logic [7:0] CMD_WRITE_KBD_OB = 8'hD2;
    localparam logic [7:0] CMD_WRITE_AUX_OB = 8'hD3;
    localparam logic [7:0] CMD_WRITE_MOUSE  = 8'hD4;
    localparam logic [7:0] CMD_RESET        = 8'hFE;

    localparam logic [7:0] SELF_TEST_OK  = 8'h55;
    localparam logic [7:0] OUTPORT_BASE  = 8'h01;
    localparam logic [7:0] OUTPORT_OBF   = 8'h10;
    localparam logic [7:0] OUTPORT_AUX   = 8'h20;

    localparam logic [7:0] STATUS_RESET  = 8'h18;
    localparam logic [7:0] MODE_RESET    = 8'h03;

    localparam int STAT_OBF      = 0;
    localparam int STAT_SELFTEST = 2;
    localparam int STAT_AUX_OBF  = 5;

    localparam int MODE_KBD_INT = 0;
    localparam int MODE_AUX_INT = 1;
    localparam int MODE_KBD_OFF = 4;
    localparam int MODE_AUX_OFF = 5;
    localparam int MODE_XLATE   = 6;

    localparam logic [1:0] READY_KBD = 2'b01;
    localparam logic [1:0] READY_AUX = 2'b10;

    typedef struct packed {
        logic                 level;
        logic [ByteWidth-1:0] data_byte;
        logic [CmdWidth-1:0]  command;
    } in_item_t;

    typedef struct packed {
        logic                 reboot_request;
        logic                 irq_aux;
        logic                 irq_keyboard;
        logic                 scan_translate;
        logic [ByteWidth-1:0] forward_byte;
        logic [KindWidth-1:0] forward_kind;
        logic [ByteWidth-1:0] status_data;
    } out_item_t;

endpackage

// File: design/kbc_core.sv
`timescale 1ns / 1ps

module kbc_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  kbc_pkg::in_item_t  item,
    output kbc_pkg::out_item_t result
);
    import kbc_pkg::*;

    logic [7:0] latched_command_reg, latched_command_next;
    logic [7:0] status_byte_reg, status_byte_next;
    logic [7:0] mode_byte_reg, mode_byte_next;
    logic [1:0] data_ready_reg, data_ready_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latched_command_reg <= CMD_NONE;
            status_byte_reg     <= STATUS_RESET;
            mode_byte_reg       <= MODE_RESET;
            data_ready_reg      <= '0;
        end
        else if (advance)
        begin
            latched_command_reg <= latched_command_next;
            status_byte_reg     <= status_byte_next;
            mode_byte_reg       <= mode_byte_next;
            data_ready_reg      <= data_ready_next;
        end
    end

    always_comb
    begin
        logic [7:0]      status_tmp;
        logic [7:0]      sdata;
        logic [7:0]      fbyte;
        fwd_kind_t       kind;
        logic            reboot;

        latched_command_next = latched_command_reg;
        status_tmp           = status_byte_reg;
        mode_byte_next       = mode_byte_reg;
        data_ready_next      = data_ready_reg;
        sdata                = '0;
        fbyte                = '0;
        kind                 = FW_NONE;
        reboot               = 1'b0;

        case (item.command)
            ACC_DATA_READ:
            begin
                kind = (data_ready_reg == READY_AUX) ? FW_READ_AUX : FW_READ_KBD;
            end
            ACC_DATA_WRITE:
            begin
                case (latched_command_reg)
                    CMD_NONE:
                    begin
                        kind  = FW_SEND_KBD;
                        fbyte = item.data_byte;
                    end
                    CMD_WRITE_MODE:   mode_byte_next = item.data_byte;
                    CMD_WRITE_KBD_OB:
                    begin
                        kind  = FW_QUEUE_KBD;
                        fbyte = item.data_byte;
                    end
                    CMD_WRITE_AUX_OB:
                    begin
                        kind  = FW_QUEUE_AUX;
                        fbyte = item.data_byte;
                    end
                    CMD_WRITE_OUTPUT: reboot = ~item.data_byte[0];
                    CMD_WRITE_MOUSE:
                    begin
                        kind  = FW_SEND_MOUSE;
                        fbyte = item.data_byte;
                    end
                    default: ;
                endcase
                latched_command_next = CMD_NONE;
            end
            ACC_STATUS_READ:
            begin
                sdata = status_byte_reg;
            end
            ACC_CMD_WRITE:
            begin
                case (item.data_byte)
                    CMD_READ_MODE:
                    begin
                        kind  = FW_QUEUE_KBD;
                        fbyte = mode_byte_reg;
                    end
                    CMD_WRITE_MODE, CMD_WRITE_OUTPUT, CMD_WRITE_KBD_OB,
                    CMD_WRITE_AUX_OB, CMD_WRITE_MOUSE:
                        latched_command_next = item.data_byte;
                    CMD_AUX_DISABLE: mode_byte_next[MODE_AUX_OFF] = 1'b1;
                    CMD_AUX_ENABLE:  mode_byte_next[MODE_AUX_OFF] = 1'b0;
                    CMD_AUX_TEST, CMD_KBD_TEST, CMD_READ_INPUT:
                        kind = FW_QUEUE_KBD;
                    CMD_SELF_TEST:
                    begin
                        status_tmp[STAT_SELFTEST] = 1'b1;
                        kind  = FW_QUEUE_KBD;
                        fbyte = SELF_TEST_OK;
                    end
                    CMD_KBD_DISABLE: mode_byte_next[MODE_KBD_OFF] = 1'b1;
                    CMD_KBD_ENABLE:  mode_byte_next[MODE_KBD_OFF] = 1'b0;
                    CMD_READ_OUTPUT:
                    begin
                        fbyte = OUTPORT_BASE
                              | (status_byte_reg[STAT_OBF] ? OUTPORT_OBF : 8'h00)
                              | (status_byte_reg[STAT_AUX_OBF] ? OUTPORT_AUX : 8'h00);
                        kind  = FW_QUEUE_KBD;
                    end
                    CMD_RESET: reboot = 1'b1;
                    default: ;
                endcase
            end
            ACC_KBD_LEVEL: data_ready_next[0] = item.level;
            ACC_AUX_LEVEL: data_ready_next[1] = item.level;
            default: ;
        endcase

        // refresh output-full flags from the pending bits
        status_byte_next               = status_tmp;
        status_byte_next[STAT_OBF]     = (data_ready_next != 2'b00);
        status_byte_next[STAT_AUX_OBF] = (data_ready_next == READY_AUX);

        result.status_data    = sdata;
        result.forward_kind   = kind;
        result.forward_byte   = fbyte;
        result.scan_translate = mode_byte_next[MODE_XLATE];
        result.irq_aux        = (data_ready_next == READY_AUX) && mode_byte_next[MODE_AUX_INT];
        result.irq_keyboard   = (data_ready_next != 2'b00) && (data_ready_next != READY_AUX)
                              && mode_byte_next[MODE_KBD_INT] && !mode_byte_next[MODE_KBD_OFF];
        result.reboot_request = reboot;
    end

endmodule

// File: design/ps2_keyboard_controller.sv
`timescale 1ns / 1ps
// Path: an accepted input item is held in the input register, which feeds decode
// and state update; the result register loads when the item advances.
// Throughput: one item per cycle while m_tready does not stall the output; an empty
// input register still takes an item while a result waits in the output register.
// Reset: rst_n asynchronous active low; status 0x18, mode 0x03, no latched
// command, no pending data, both registers empty.

module ps2_keyboard_controller
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // command[2:0], data_byte[10:3], level[11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status_data[7:0], forward_kind[10:8], forward_byte[18:11],
                                   // scan_translate[19], irq_keyboard[20], irq_aux[21],
                                   // reboot_request[22], zero pad
);
    import kbc_pkg::*;

    localparam int InBits  = $bits(in_item_t);
    localparam int OutBits = $bits(out_item_t);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t result;
    logic      advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= in_item_t'(s_tdata[InBits-1:0]);
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    kbc_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(24 - OutBits){1'b0}}, out_item_reg};

endmodule
